### rtl/sppu_pkg.sv
// Shared types and constants for the system-exclusive preset/state parser.
// Used by the front, queue, back and top level modules; no dependencies.
package sppu_pkg;

  localparam logic [7:0] ByteStart = 8'hF0;
  localparam logic [7:0] ByteEnd   = 8'hF7;
  localparam logic [7:0] FnPreset  = 8'h14;
  localparam logic [7:0] FnUpdate  = 8'h0E;
  localparam logic [7:0] FnRequest = 8'h21;

  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [1:0] KindPreset  = 2'd0;
  localparam logic [1:0] KindRequest = 2'd1;
  localparam logic [1:0] KindEffect  = 2'd2;
  localparam logic [1:0] KindBegin   = 2'd3;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_END   = 2'd1,
    OP_DATA  = 2'd2
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } cmd_t;

  function automatic logic [7:0] header_byte(input logic [1:0] k);
    logic [7:0] b;
    case (k)
      2'd0:    b = 8'h00;
      2'd1:    b = 8'h01;
      2'd2:    b = 8'h74;
      default: b = 8'h03;
    endcase
    return b;
  endfunction

endpackage

### rtl/sppu_front.sv
// Input side: accepts words and tags them as start, end or data commands.
// Depends on sppu_pkg.
module sppu_front (
  input  logic              in_valid_i,
  input  logic [7:0]        data_byte_i,
  input  logic              q_full_i,
  output logic              in_stall_o,
  output logic              push_o,
  output sppu_pkg::cmd_t    cmd_o
);
  import sppu_pkg::*;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    cmd_o.data = data_byte_i;
    if (data_byte_i == ByteStart) begin
      cmd_o.op = OP_START;
    end else if (data_byte_i == ByteEnd) begin
      cmd_o.op = OP_END;
    end else begin
      cmd_o.op = OP_DATA;
    end
  end

endmodule

### rtl/sppu_queue.sv
// Short command queue between the front and back sides.
// Depends on sppu_pkg.
module sppu_queue #(
  parameter int unsigned Depth = sppu_pkg::QueueDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sppu_pkg::cmd_t    cmd_i,
  input  logic              pop_i,
  output sppu_pkg::cmd_t    cmd_o,
  output logic              empty_o,
  output logic              full_o
);
  import sppu_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == FullCnt);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

### rtl/sppu_back.sv
// Back side: message state, header and checksum tracking, record decode,
// and the output register. Depends on sppu_pkg.
module sppu_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sppu_pkg::cmd_t    cmd_i,
  input  logic              q_empty_i,
  output logic              pop_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [1:0]        event_kind_o,
  output logic [14:0]       preset_number_o,
  output logic [7:0]        effect_id_o,
  output logic [7:0]        effect_value_o,
  output logic              flag_first_o,
  output logic              flag_second_o
);
  import sppu_pkg::*;

  logic       in_msg_q, in_msg_d;
  logic [2:0] byte_idx_q, byte_idx_d;
  logic       hdr_good_q, hdr_good_d;
  logic [7:0] fn_q, fn_d;
  logic [6:0] xor_q, xor_d;
  logic [6:0] ph_q, ph_d, pl_q, pl_d;
  logic [2:0] rec_idx_q, rec_idx_d;
  logic [7:0] rec_q [4];
  logic       rec_we;

  logic        emit;
  logic [1:0]  kind;
  logic [14:0] preset;
  logic [7:0]  eff_id, eff_val;
  logic        f1, f2;
  logic        out_valid_q;
  logic [7:0]  b;

  assign b           = cmd_i.data;
  assign pop_o       = !q_empty_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    in_msg_d   = in_msg_q;
    byte_idx_d = byte_idx_q;
    hdr_good_d = hdr_good_q;
    fn_d       = fn_q;
    xor_d      = xor_q;
    ph_d       = ph_q;
    pl_d       = pl_q;
    rec_idx_d  = rec_idx_q;
    rec_we     = 1'b0;
    emit       = 1'b0;
    kind       = KindPreset;
    preset     = '0;
    eff_id     = '0;
    eff_val    = '0;
    f1         = 1'b0;
    f2         = 1'b0;
    case (cmd_i.op)
      OP_START: begin
        in_msg_d   = 1'b1;
        byte_idx_d = '0;
        hdr_good_d = 1'b1;
        fn_d       = '0;
        xor_d      = ByteStart[6:0];
        ph_d       = '0;
        pl_d       = '0;
        rec_idx_d  = '0;
      end
      OP_END: begin
        if (in_msg_q) begin
          in_msg_d = 1'b0;
          if (hdr_good_q && byte_idx_q >= 3'd5 && xor_q == '0) begin
            if (fn_q == FnPreset) begin
              emit   = 1'b1;
              kind   = KindPreset;
              preset = {1'b0, ph_q, pl_q} + 15'd1;
            end else if (fn_q == FnRequest) begin
              emit = 1'b1;
              kind = KindRequest;
            end
          end
        end
      end
      OP_DATA: begin
        if (in_msg_q) begin
          xor_d = xor_q ^ b[6:0];
          if (byte_idx_q != 3'd7) begin
            byte_idx_d = byte_idx_q + 3'd1;
          end
          if (hdr_good_q) begin
            if (byte_idx_q < 3'd4) begin
              if (b != header_byte(byte_idx_q[1:0])) begin
                hdr_good_d = 1'b0;
              end
            end else if (byte_idx_q == 3'd4) begin
              fn_d = b;
              if (b == FnUpdate) begin
                emit = 1'b1;
                kind = KindBegin;
              end
            end else begin
              if (byte_idx_q == 3'd5) begin
                ph_d = b[6:0];
              end else if (byte_idx_q == 3'd6) begin
                pl_d = b[6:0];
              end
              if (fn_q == FnUpdate) begin
                if (rec_idx_q < 3'd4) begin
                  rec_we    = 1'b1;
                  rec_idx_d = rec_idx_q + 3'd1;
                end else begin
                  rec_idx_d = '0;
                  emit      = 1'b1;
                  kind      = KindEffect;
                  eff_id    = {b[3:0], rec_q[3][6:3]};
                  eff_val   = {rec_q[2][1:0], rec_q[1][6:1]};
                  f1        = !rec_q[0][0];
                  f2        = !rec_q[0][1];
                end
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_msg_q    <= 1'b0;
      byte_idx_q  <= '0;
      hdr_good_q  <= 1'b0;
      fn_q        <= '0;
      xor_q       <= '0;
      ph_q        <= '0;
      pl_q        <= '0;
      rec_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        in_msg_q   <= in_msg_d;
        byte_idx_q <= byte_idx_d;
        hdr_good_q <= hdr_good_d;
        fn_q       <= fn_d;
        xor_q      <= xor_d;
        ph_q       <= ph_d;
        pl_q       <= pl_d;
        rec_idx_q  <= rec_idx_d;
      end
      if (pop_o && emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && rec_we) begin
      rec_q[rec_idx_q[1:0]] <= b;
    end
    if (pop_o && emit) begin
      event_kind_o    <= kind;
      preset_number_o <= preset;
      effect_id_o     <= eff_id;
      effect_value_o  <= eff_val;
      flag_first_o    <= f1;
      flag_second_o   <= f2;
    end
  end

endmodule

### rtl/sysex_preset_state_parser_unit.sv
// Top level of the system-exclusive preset/state parser.
// Instantiates sppu_front, sppu_queue and sppu_back; depends on sppu_pkg.
//
// Takes one MIDI word per cycle on the input channel while the input is not
// stalled and issues at most one event per word: update begins, effect
// record, states requested, or preset shown. A word is written into the
// command queue at the edge that accepts it, and its event is registered in
// the output register when the back end pops and decodes it. The sustained
// rate is one word per cycle while the output is not stalled, set by the
// state update in the back end. The input stalls only when the command queue
// is full, which happens while the output side holds a result under stall.
module sysex_preset_state_parser_unit #(
  parameter int unsigned QueueDepth = sppu_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  event_kind_o,
  output logic [14:0] preset_number_o,
  output logic [7:0]  effect_id_o,
  output logic [7:0]  effect_value_o,
  output logic        flag_first_o,
  output logic        flag_second_o
);
  import sppu_pkg::*;

  cmd_t front_cmd, q_cmd;
  logic push, pop, q_empty, q_full;

  sppu_front u_front (
    .in_valid_i  (in_valid_i),
    .data_byte_i (data_byte_i),
    .q_full_i    (q_full),
    .in_stall_o  (in_stall_o),
    .push_o      (push),
    .cmd_o       (front_cmd)
  );

  sppu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .pop_i   (pop),
    .cmd_o   (q_cmd),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  sppu_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (q_cmd),
    .q_empty_i       (q_empty),
    .pop_o           (pop),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .event_kind_o    (event_kind_o),
    .preset_number_o (preset_number_o),
    .effect_id_o     (effect_id_o),
    .effect_value_o  (effect_value_o),
    .flag_first_o    (flag_first_o),
    .flag_second_o   (flag_second_o)
  );

  a_new_result_from_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (!$past(out_valid_o) || !$past(out_stall_i))) |-> $past(pop))
    else $error("result appeared without a queued word");

  a_effect_fields_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_kind_o != KindEffect) |->
      (effect_id_o == '0 && effect_value_o == '0 && !flag_first_o && !flag_second_o))
    else $error("effect fields set on a non-record event");

  a_preset_field_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_kind_o != KindPreset) |-> (preset_number_o == '0))
    else $error("preset number set on a non-preset event");

  a_no_pop_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !pop)
    else $error("queue popped while result is held");

endmodule

### tb/sppu_event_checker.sv
// Checker for the system-exclusive preset/state parser: watches both channels,
// predicts the events of each accepted word and compares them in order.
// Depends on sppu_pkg for the message codes and event kinds.
`timescale 1ns / 1ps

module sppu_event_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  event_kind_i,
  input  logic [14:0] preset_number_i,
  input  logic [7:0]  effect_id_i,
  input  logic [7:0]  effect_value_i,
  input  logic        flag_first_i,
  input  logic        flag_second_i,
  output int          fail_count_o,
  output int          outstanding_o
);
  import sppu_pkg::*;

  localparam logic [7:0] SysexHeader [4] = '{8'h00, 8'h01, 8'h74, 8'h03};
  localparam logic [6:0] StartXor = 7'h70;

  typedef struct packed {
    logic [1:0]  kind;
    logic [14:0] preset;
    logic [7:0]  id;
    logic [7:0]  value;
    logic        flag_first;
    logic        flag_second;
  } parser_event_t;

  parser_event_t pending_events[$];
  int            fails;

  logic       msg_open;
  logic [2:0] msg_index;
  logic       header_ok;
  logic [7:0] fn_code;
  logic [6:0] run_xor;
  logic [6:0] preset_hi;
  logic [6:0] preset_lo;
  logic [7:0] rec_bytes [4];
  logic [2:0] rec_count;

  task automatic clear_parser();
    msg_open  = 1'b0;
    msg_index = '0;
    header_ok = 1'b0;
    fn_code   = '0;
    run_xor   = '0;
    preset_hi = '0;
    preset_lo = '0;
    rec_count = '0;
    for (int i = 0; i < 4; i++) rec_bytes[i] = '0;
  endtask

  task automatic decode_word(input logic [7:0] b);
    logic [2:0]    k;
    parser_event_t ev;
    ev = '0;
    if (b == ByteStart) begin
      msg_open  = 1'b1;
      msg_index = '0;
      header_ok = 1'b1;
      fn_code   = '0;
      run_xor   = StartXor;
      preset_hi = '0;
      preset_lo = '0;
      rec_count = '0;
    end else if (msg_open && b == ByteEnd) begin
      msg_open = 1'b0;
      if (header_ok && msg_index >= 3'd5 && run_xor == '0) begin
        if (fn_code == FnPreset) begin
          ev.kind   = KindPreset;
          ev.preset = {1'b0, preset_hi, preset_lo} + 15'd1;
          pending_events.push_back(ev);
        end else if (fn_code == FnRequest) begin
          ev.kind = KindRequest;
          pending_events.push_back(ev);
        end
      end
    end else if (msg_open) begin
      run_xor = run_xor ^ b[6:0];
      k = msg_index;
      if (msg_index < 3'd7) msg_index = msg_index + 3'd1;
      if (header_ok) begin
        if (k < 3'd4) begin
          if (b != SysexHeader[k[1:0]]) header_ok = 1'b0;
        end else if (k == 3'd4) begin
          fn_code = b;
          if (b == FnUpdate) begin
            ev.kind = KindBegin;
            pending_events.push_back(ev);
          end
        end else begin
          if (k == 3'd5) preset_hi = b[6:0];
          else if (k == 3'd6) preset_lo = b[6:0];
          if (fn_code == FnUpdate) begin
            if (rec_count < 3'd4) begin
              rec_bytes[rec_count[1:0]] = b;
              rec_count = rec_count + 3'd1;
            end else begin
              rec_count      = '0;
              ev.kind        = KindEffect;
              ev.id          = {b[3:0], rec_bytes[3][6:3]};
              ev.value       = {rec_bytes[2][1:0], rec_bytes[1][6:1]};
              ev.flag_first  = ~rec_bytes[0][0];
              ev.flag_second = ~rec_bytes[0][1];
              pending_events.push_back(ev);
            end
          end
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [14:0] want,
                             input logic [14:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    parser_event_t want;
    if (!rst_ni) begin
      clear_parser();
      pending_events.delete();
      fails = 0;
      fail_count_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_events.size() == 0) begin
          $error("event_kind: expected none, actual %0h", event_kind_i);
          fails++;
        end else begin
          want = pending_events.pop_front();
          check_field("event_kind", 15'(want.kind), 15'(event_kind_i));
          check_field("preset_number", want.preset, preset_number_i);
          check_field("effect_id", 15'(want.id), 15'(effect_id_i));
          check_field("effect_value", 15'(want.value), 15'(effect_value_i));
          check_field("flag_first", 15'(want.flag_first), 15'(flag_first_i));
          check_field("flag_second", 15'(want.flag_second), 15'(flag_second_i));
        end
      end
      if (in_valid_i && !in_stall_i) decode_word(data_byte_i);
      fail_count_o  <= fails;
      outstanding_o <= pending_events.size();
    end
  end

endmodule

### tb/sysex_preset_state_parser_unit_test.sv
// Testbench top for sysex_preset_state_parser_unit: drives MIDI words with
// bursts and gaps, stalls the event side, and reports the checker's verdict.
// Depends on sppu_pkg, the parser RTL and sppu_event_checker.
`timescale 1ns / 1ps

module sysex_preset_state_parser_unit_test;
  import sppu_pkg::*;

  localparam logic [7:0] FnTempo = 8'h10;
  localparam logic [7:0] FnTuner = 8'h0D;
  localparam logic [7:0] SysexHeader [4] = '{8'h00, 8'h01, 8'h74, 8'h03};
  localparam int RandomWords = 950;
  localparam int HoldStart   = 300;
  localparam int HoldCycles  = 250;
  localparam int DrainCycles = 8;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  event_kind;
  logic [14:0] preset_number;
  logic [7:0]  effect_id;
  logic [7:0]  effect_value;
  logic        flag_first;
  logic        flag_second;
  int          fail_count;
  int          outstanding;

  logic [7:0] frame[$];
  int         words_sent;
  int         burst_left;

  sysex_preset_state_parser_unit DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .data_byte_i     (data_byte),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .event_kind_o    (event_kind),
    .preset_number_o (preset_number),
    .effect_id_o     (effect_id),
    .effect_value_o  (effect_value),
    .flag_first_o    (flag_first),
    .flag_second_o   (flag_second)
  );

  sppu_event_checker u_monitor (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .data_byte_i     (data_byte),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .event_kind_i    (event_kind),
    .preset_number_i (preset_number),
    .effect_id_i     (effect_id),
    .effect_value_i  (effect_value),
    .flag_first_i    (flag_first),
    .flag_second_i   (flag_second),
    .fail_count_o    (fail_count),
    .outstanding_o   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // any byte that is not a message delimiter
  function automatic logic [7:0] rand_data();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == ByteStart || b == ByteEnd) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  task automatic send_word(input logic [7:0] b);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    words_sent++;
  endtask

  task automatic send_frame();
    foreach (frame[i]) send_word(frame[i]);
    frame.delete();
  endtask

  task automatic open_message(input logic [7:0] fn);
    frame.push_back(ByteStart);
    foreach (SysexHeader[i]) frame.push_back(SysexHeader[i]);
    frame.push_back(fn);
  endtask

  task automatic add_payload(input int n);
    repeat (n) frame.push_back(rand_data());
  endtask

  // checksum over the last message of the frame, optionally broken in one bit
  task automatic close_message(input bit corrupt);
    logic [6:0] acc;
    acc = '0;
    foreach (frame[i]) begin
      if (frame[i] == ByteStart) acc = '0;
      acc = acc ^ frame[i][6:0];
    end
    if (corrupt) acc = acc ^ (7'd1 << $urandom_range(0, 6));
    frame.push_back({1'b0, acc});
    frame.push_back(ByteEnd);
  endtask

  task automatic random_message();
    int sel;
    int pos;
    sel = $urandom_range(0, 99);
    if (sel < 22) begin
      open_message(FnPreset);
      add_payload(($urandom_range(0, 4) == 0) ? $urandom_range(0, 4) : 2);
      close_message(1'b0);
    end else if (sel < 34) begin
      open_message(FnRequest);
      add_payload($urandom_range(0, 3));
      close_message(1'b0);
    end else if (sel < 64) begin
      open_message(FnUpdate);
      add_payload(5 * $urandom_range(0, 4) + $urandom_range(0, 4));
      if ($urandom_range(0, 1) != 0) close_message(1'b0);
      else frame.push_back(ByteEnd);
    end else if (sel < 72) begin
      open_message(($urandom_range(0, 1) != 0) ? FnPreset : FnRequest);
      add_payload($urandom_range(0, 3));
      close_message(1'b1);
    end else if (sel < 78) begin
      case ($urandom_range(0, 2))
        0:       open_message(FnTempo);
        1:       open_message(FnTuner);
        default: open_message(rand_data());
      endcase
      add_payload($urandom_range(0, 6));
      close_message(1'b0);
    end else if (sel < 85) begin
      open_message(($urandom_range(0, 1) != 0) ? FnPreset : FnUpdate);
      pos = $urandom_range(1, 4);
      while (frame[pos] == SysexHeader[pos - 1]) frame[pos] = rand_data();
      add_payload($urandom_range(0, 10));
      close_message(1'b0);
    end else if (sel < 91) begin
      frame.push_back(ByteStart);
      pos = $urandom_range(0, 4);
      for (int i = 0; i < pos; i++) frame.push_back(SysexHeader[i]);
      frame.push_back(ByteEnd);
    end else if (sel < 96) begin
      // dropped by the next start byte
      open_message(($urandom_range(0, 1) != 0) ? FnPreset : FnUpdate);
      add_payload($urandom_range(0, 7));
      frame = frame[0:$urandom_range(0, frame.size() - 1)];
    end else begin
      repeat ($urandom_range(1, 4)) begin
        pos = $urandom_range(0, 255);
        frame.push_back((pos == ByteStart) ? ByteEnd : 8'(pos));
      end
    end
    send_frame();
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    data_byte  <= 8'h00;
    words_sent = 0;
    burst_left = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // end byte with no message open
    frame.push_back(ByteEnd);
    // largest preset field
    open_message(FnPreset);
    frame.push_back(8'h7F);
    frame.push_back(8'h7F);
    close_message(1'b0);
    open_message(FnRequest);
    close_message(1'b0);
    // one full effect record, then a partial one cut off by the end byte
    open_message(FnUpdate);
    frame.push_back(8'hFC);
    frame.push_back(8'hFF);
    frame.push_back(8'h03);
    frame.push_back(8'hFF);
    frame.push_back(8'h0F);
    frame.push_back(8'h00);
    frame.push_back(8'h80);
    frame.push_back(ByteEnd);
    // start byte inside a message, then a short preset message
    frame.push_back(ByteStart);
    frame.push_back(8'h00);
    open_message(FnPreset);
    send_frame();
    open_message(FnPreset);
    close_message(1'b0);
    send_frame();

    while (words_sent < RandomWords) random_message();

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    int cyc;
    int mode;
    int left;
    out_stall <= 1'b0;
    cyc  = 0;
    mode = 0;
    left = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      cyc++;
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(10, 80);
      end
      left--;
      if (cyc >= HoldStart && cyc < HoldStart + HoldCycles) begin
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

endmodule
